FILE: rtl/ppm_pkg.sv
// Shared types and constants for the P6 PPM stream decoder.
// Used by ppm_front, ppm_queue, ppm_back and the top level; no dependencies.
package ppm_pkg;

    localparam int DefaultMaxDim     = 4096;
    localparam int DefaultQueueDepth = 4;

    localparam logic [7:0]  CharP     = 8'h50;
    localparam logic [7:0]  Char6     = 8'h36;
    localparam logic [7:0]  CharZero  = 8'h30;
    localparam logic [7:0]  CharNine  = 8'h39;
    localparam logic [7:0]  CharSpace = 8'h20;
    localparam logic [7:0]  CharTab   = 8'h09;
    localparam logic [7:0]  CharLf    = 8'h0A;
    localparam logic [7:0]  CharCr    = 8'h0D;
    localparam logic [7:0]  CharHash  = 8'h23;
    localparam logic [12:0] MaxvalOk  = 13'd255;
    localparam logic [12:0] AccLimit  = 13'd8191;
    localparam logic [7:0]  AlphaOpaque = 8'hFF;

    typedef enum logic [2:0] {
        PH_MAGIC_P,
        PH_MAGIC_6,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_PIXELS,
        PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_HEADER,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_MAGIC,
        ERR_VALUE,
        ERR_TRUNC
    } err_code_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] rgb;
        logic [12:0] width;
        logic [12:0] height;
        logic        fin;
        err_code_t   code;
    } cmd_t;

endpackage

FILE: rtl/ppm_p6_stream_decoder.sv
// Path: a result item reaches the master side through the queue entry register,
// then the output register, after the byte that caused it is accepted.
// Throughput: one byte per cycle; stalls on a full queue.
// Reset: synchronous, active-low aresetn clears the parser, the queue and the output valid.
// Top level of the P6 PPM stream decoder; instantiates ppm_front, ppm_queue
// and ppm_back, and depends on ppm_pkg.
module ppm_p6_stream_decoder
    import ppm_pkg::*;
#(
    parameter int MAX_DIM     = DefaultMaxDim,
    parameter int QUEUE_DEPTH = DefaultQueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // argb[31:0], width_out[44:32], height_out[57:45],
                                   // error_code[59:58], zero fill
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t pop_cmd;
    logic not_empty;
    logic not_full;

    ppm_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_eof   (s_tlast),
        .space_ok (not_full),
        .in_ready (s_tready),
        .push     (push),
        .cmd      (push_cmd)
    );

    ppm_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    ppm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (not_empty),
        .q_cmd       (pop_cmd),
        .q_pop       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: rtl/ppm_front.sv
// Byte parser: header, comments, validation and RGB triple assembly.
// Emits one cmd_t per result into the queue; depends on ppm_pkg.
module ppm_front
    import ppm_pkg::*;
#(
    parameter int MAX_DIM = DefaultMaxDim
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_eof,
    input  logic       space_ok,
    output logic       in_ready,
    output logic       push,
    output cmd_t       cmd
);

    localparam logic [12:0] MaxDimVal = 13'(MAX_DIM);

    phase_t      phase_reg, phase_next;
    logic        in_comment_reg, in_comment_next;
    logic        in_digits_reg, in_digits_next;
    logic [12:0] number_acc_reg, number_acc_next;
    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic [24:0] pixels_left_reg, pixels_left_next;
    logic [1:0]  byte_in_triple_reg, byte_in_triple_next;
    logic [15:0] red_green_hold_reg, red_green_hold_next;

    logic        accept;
    logic        emit;
    logic        own_error;
    logic        bad;
    logic        is_digit;
    logic        is_blank;
    logic        is_hash;
    logic [16:0] acc_ext;
    logic [16:0] acc_sum;
    logic [25:0] area;
    logic [24:0] pixels_dec;

    assign in_ready = space_ok;
    assign accept   = in_valid && space_ok;
    assign push     = accept && emit;

    assign is_digit = (in_byte >= CharZero) && (in_byte <= CharNine);
    assign is_blank = (in_byte == CharSpace) || (in_byte == CharTab) ||
                      (in_byte == CharLf) || (in_byte == CharCr);
    assign is_hash  = (in_byte == CharHash);
    assign acc_ext  = {4'b0, number_acc_reg};
    assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + {13'b0, in_byte[3:0]};
    assign area     = {13'b0, width_reg} * {13'b0, height_reg};

    always_comb begin
        phase_next          = phase_reg;
        in_comment_next     = in_comment_reg;
        in_digits_next      = in_digits_reg;
        number_acc_next     = number_acc_reg;
        width_next          = width_reg;
        height_next         = height_reg;
        pixels_left_next    = pixels_left_reg;
        byte_in_triple_next = byte_in_triple_reg;
        red_green_hold_next = red_green_hold_reg;
        emit                = 1'b0;
        own_error           = 1'b0;
        bad                 = 1'b0;
        cmd                 = '0;
        pixels_dec          = pixels_left_reg;

        unique case (phase_reg)
            PH_MAGIC_P, PH_MAGIC_6: begin
                if (in_byte != ((phase_reg == PH_MAGIC_P) ? CharP : Char6)) begin
                    emit       = 1'b1;
                    own_error  = 1'b1;
                    cmd.kind   = KIND_ERROR;
                    cmd.code   = ERR_MAGIC;
                    phase_next = PH_DRAIN;
                end else begin
                    phase_next = (phase_reg == PH_MAGIC_P) ? PH_MAGIC_6 : PH_WIDTH;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                if (in_comment_reg) begin
                    if (in_byte == CharLf) begin
                        in_comment_next = 1'b0;
                    end
                end else if (is_digit) begin
                    number_acc_next = (acc_sum > {4'b0, AccLimit}) ? AccLimit
                                                                 : acc_sum[12:0];
                    in_digits_next  = 1'b1;
                end else if (in_digits_reg) begin
                    if (phase_reg == PH_MAXVAL) begin
                        in_digits_next = 1'b0;
                        if (width_reg == '0 || height_reg == '0 ||
                            number_acc_reg != MaxvalOk ||
                            width_reg > MaxDimVal || height_reg > MaxDimVal) begin
                            bad = 1'b1;
                        end else begin
                            emit                = 1'b1;
                            cmd.kind            = KIND_HEADER;
                            cmd.width           = width_reg;
                            cmd.height          = height_reg;
                            pixels_left_next    = area[24:0];
                            byte_in_triple_next = 2'd0;
                            red_green_hold_next = '0;
                            phase_next          = PH_PIXELS;
                        end
                        number_acc_next = '0;
                    end else begin
                        if (phase_reg == PH_WIDTH) begin
                            width_next = number_acc_reg;
                            phase_next = PH_HEIGHT;
                        end else begin
                            height_next = number_acc_reg;
                            phase_next  = PH_MAXVAL;
                        end
                        number_acc_next = '0;
                        in_digits_next  = 1'b0;
                        bad             = !is_blank && !is_hash;
                        if (is_hash) begin
                            in_comment_next = 1'b1;
                        end
                    end
                end else begin
                    bad = !is_blank && !is_hash;
                    if (is_hash) begin
                        in_comment_next = 1'b1;
                    end
                end
                if (bad) begin
                    emit       = 1'b1;
                    own_error  = 1'b1;
                    cmd        = '0;
                    cmd.kind   = KIND_ERROR;
                    cmd.code   = ERR_VALUE;
                    phase_next = PH_DRAIN;
                end
            end
            PH_PIXELS: begin
                if (byte_in_triple_reg == 2'd0) begin
                    red_green_hold_next = {in_byte, 8'h00};
                    byte_in_triple_next = 2'd1;
                end else if (byte_in_triple_reg == 2'd1) begin
                    red_green_hold_next = {red_green_hold_reg[15:8], in_byte};
                    byte_in_triple_next = 2'd2;
                end else begin
                    if (pixels_left_reg != '0) begin
                        pixels_dec = pixels_left_reg - 25'd1;
                    end
                    pixels_left_next    = pixels_dec;
                    emit                = 1'b1;
                    cmd.kind            = KIND_PIXEL;
                    cmd.rgb             = {red_green_hold_reg, in_byte};
                    cmd.fin             = (pixels_dec == '0);
                    byte_in_triple_next = 2'd0;
                    if (pixels_dec == '0) begin
                        phase_next = PH_DRAIN;
                    end
                end
            end
            PH_DRAIN: begin
                phase_next = PH_DRAIN;
            end
            default: begin
                phase_next = PH_DRAIN;
            end
        endcase

        if (in_eof) begin
            if (phase_next != PH_DRAIN && !own_error) begin
                emit     = 1'b1;
                cmd      = '0;
                cmd.kind = KIND_ERROR;
                cmd.code = ERR_TRUNC;
            end
            phase_next          = PH_MAGIC_P;
            in_comment_next     = 1'b0;
            in_digits_next      = 1'b0;
            number_acc_next     = '0;
            width_next          = '0;
            height_next         = '0;
            pixels_left_next    = '0;
            byte_in_triple_next = 2'd0;
            red_green_hold_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_MAGIC_P;
            in_comment_reg     <= 1'b0;
            in_digits_reg      <= 1'b0;
            number_acc_reg     <= '0;
            width_reg          <= '0;
            height_reg         <= '0;
            pixels_left_reg    <= '0;
            byte_in_triple_reg <= 2'd0;
            red_green_hold_reg <= '0;
        end else if (accept) begin
            phase_reg          <= phase_next;
            in_comment_reg     <= in_comment_next;
            in_digits_reg      <= in_digits_next;
            number_acc_reg     <= number_acc_next;
            width_reg          <= width_next;
            height_reg         <= height_next;
            pixels_left_reg    <= pixels_left_next;
            byte_in_triple_reg <= byte_in_triple_next;
            red_green_hold_reg <= red_green_hold_next;
        end
    end

`ifndef SYNTH
    a_pixels_have_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PIXELS) |-> (width_reg != '0 && height_reg != '0))
        else $error("pixel phase entered with a zero dimension");
    a_pixels_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PIXELS) |-> (pixels_left_reg != '0))
        else $error("pixel phase with no pixels left");
    a_triple_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_in_triple_reg != 2'd3)
        else $error("triple byte counter out of range");
`endif

endmodule

FILE: rtl/ppm_queue.sv
// Short FIFO of parsed result commands between the parser and the output stage.
// Depends on ppm_pkg for cmd_t.
module ppm_queue
    import ppm_pkg::*;
#(
    parameter int DEPTH = DefaultQueueDepth
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic not_empty,
    output logic not_full
);

    localparam int AddrW  = $clog2(DEPTH);
    localparam int CountW = $clog2(DEPTH + 1);

    cmd_t              entry_reg [DEPTH];
    logic [AddrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != CountW'(DEPTH));
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountW'(DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> not_full)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from an empty queue");
`endif

endmodule

FILE: rtl/ppm_back.sv
// Output stage: formats queued commands into result items and holds them
// in a register until the downstream side takes them. Depends on ppm_pkg.
module ppm_back
    import ppm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_not_empty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic        valid_reg;
    kind_t       kind_reg;
    logic [31:0] argb_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic        fin_reg;
    err_code_t   code_reg;

    assign q_pop    = q_not_empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = fin_reg;
    assign m_tdata  = {4'b0, code_reg, height_reg, width_reg, argb_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg   <= q_cmd.kind;
            argb_reg   <= (q_cmd.kind == KIND_PIXEL) ? {AlphaOpaque, q_cmd.rgb} : '0;
            width_reg  <= q_cmd.width;
            height_reg <= q_cmd.height;
            fin_reg    <= q_cmd.fin;
            code_reg   <= q_cmd.code;
        end
    end

endmodule
